>>> hw/rtl/brf_pkg.sv
// ---------------------------------------------------------------------------
// brf_pkg
// Shared codes and types for the circular byte FIFO.
// ---------------------------------------------------------------------------
package brf_pkg;

	// operation codes carried on the input tuser
	localparam logic [2:0] OP_WRITE   = 3'd0;
	localparam logic [2:0] OP_READ    = 3'd1;
	localparam logic [2:0] OP_PEEK    = 3'd2;
	localparam logic [2:0] OP_ADVANCE = 3'd3;
	localparam logic [2:0] OP_RESET   = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BEYOND = 2'd2;

	// result fields known when the transaction is accepted
	typedef struct packed {
		logic       rd_valid;
		logic [9:0] used;
		logic [9:0] free;
		logic [1:0] status;
	} brf_meta_t;

endpackage

>>> hw/rtl/brf_store.sv
// ---------------------------------------------------------------------------
// brf_store
// Byte store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module brf_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [0:DEPTH-1];
	logic [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data registered in the cycle after the request
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/brf_ctrl.sv
// ---------------------------------------------------------------------------
// brf_ctrl
// Read and write pointers, operation decode and store requests.
// ---------------------------------------------------------------------------
module brf_ctrl #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [2:0]         op,
	input  logic [7:0]         data,
	input  logic [9:0]         arg,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [7:0]         mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	output brf_pkg::brf_meta_t meta
);
	import brf_pkg::*;

	// arithmetic width: holds DEPTH itself and any ten-bit argument
	localparam int CW = ((AW > 10) ? AW : 10) + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] LAST_C  = CW'(DEPTH - 1);

	logic [AW-1:0] rd_idx_q, wr_idx_q;
	logic [AW-1:0] rd_idx_n, wr_idx_n;
	logic [CW-1:0] rd_w, wr_w, arg_w, used, used_n, free_w, amt, peek_sum, adv_sum;
	logic          we_c, re_c;
	logic [AW-1:0] raddr_c;
	logic [1:0]    status_c;
	logic          valid_c;

	always_comb begin
		rd_w  = CW'(rd_idx_q);
		wr_w  = CW'(wr_idx_q);
		arg_w = CW'(arg);
		// occupancy from the two pointers
		if (wr_w >= rd_w) begin
			used = wr_w - rd_w;
		end else begin
			used = DEPTH_C - rd_w + wr_w;
		end
		amt      = (arg_w > used) ? used : arg_w;
		// wrap sums below twice the depth
		peek_sum = rd_w + arg_w;
		if (peek_sum >= DEPTH_C) peek_sum = peek_sum - DEPTH_C;
		adv_sum  = rd_w + amt;
		if (adv_sum >= DEPTH_C) adv_sum = adv_sum - DEPTH_C;
	end

	// operation decode
	always_comb begin
		we_c     = 1'b0;
		re_c     = 1'b0;
		raddr_c  = rd_idx_q;
		status_c = ST_OK;
		valid_c  = 1'b0;
		rd_idx_n = rd_idx_q;
		wr_idx_n = wr_idx_q;
		used_n   = used;
		unique case (op)
			OP_WRITE: begin
				if (used >= LAST_C) begin
					status_c = ST_FULL;
				end else begin
					we_c     = 1'b1;
					wr_idx_n = (wr_w == LAST_C) ? '0 : wr_idx_q + AW'(1);
					used_n   = used + CW'(1);
				end
			end
			OP_READ: begin
				if (used == '0) begin
					status_c = ST_BEYOND;
				end else begin
					re_c     = 1'b1;
					valid_c  = 1'b1;
					rd_idx_n = (rd_w == LAST_C) ? '0 : rd_idx_q + AW'(1);
					used_n   = used - CW'(1);
				end
			end
			OP_PEEK: begin
				if (arg_w >= used) begin
					status_c = ST_BEYOND;
				end else begin
					re_c    = 1'b1;
					valid_c = 1'b1;
					raddr_c = peek_sum[AW-1:0];
				end
			end
			OP_ADVANCE: begin
				if (arg_w > used) status_c = ST_BEYOND;
				rd_idx_n = adv_sum[AW-1:0];
				used_n   = used - amt;
			end
			OP_RESET: begin
				rd_idx_n = '0;
				wr_idx_n = '0;
				used_n   = '0;
			end
			default: begin
			end
		endcase
		free_w = LAST_C - used_n;
	end

	// pointer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			wr_idx_q <= '0;
		end else if (accept) begin
			rd_idx_q <= rd_idx_n;
			wr_idx_q <= wr_idx_n;
		end
	end

	assign mem_we        = accept & we_c;
	assign mem_waddr     = wr_idx_q;
	assign mem_wdata     = data;
	assign mem_re        = accept & re_c;
	assign mem_raddr     = raddr_c;
	assign meta.rd_valid = valid_c;
	assign meta.used     = used_n[9:0];
	assign meta.free     = free_w[9:0];
	assign meta.status   = status_c;

	// checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used <= LAST_C) else $error("occupancy above depth minus one");
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_w < DEPTH_C) && (wr_w < DEPTH_C)) else $error("pointer out of range");
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re)) else $error("store read and write in one transaction");
	a_write_moves: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (wr_idx_q != $past(wr_idx_q))) else $error("write pointer stuck");

endmodule

>>> hw/rtl/byte_ring_fifo_unit.sv
// ---------------------------------------------------------------------------
// byte_ring_fifo_unit
// Circular byte FIFO with one slot kept empty; one result per operation.
// ---------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  s_*     | in  | data_byte[7:0], offset_or_count[17:8]       | operation[2:0]
//  m_*     | out | read_byte[7:0], used_count[17:8],           | read_valid[0],
//          |     | free_count[27:18]                           | status[2:1]
//
//  One operation per clock while the input is not stalled; a result passes
//  through the store read stage and then the output register.
//  Pointers update at acceptance, so consecutive operations see each other.
//  Reset clears both pointers; the store is not cleared.
//  A stalled output holds its result; input stalls only when both the
//  store read stage and the output register are full.
// ---------------------------------------------------------------------------
module byte_ring_fifo_unit #(
	parameter int DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // data_byte[7:0], offset_or_count[17:8]
	input  logic [2:0]  s_tuser,   // operation[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // read_byte[7:0], used_count[17:8], free_count[27:18]
	output logic [2:0]  m_tuser    // read_valid[0], status[2:1]
);
	import brf_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          accept, s1_move;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;
	brf_meta_t     meta, meta_s1, meta_q;
	logic          valid_s1, out_valid_q;
	logic [7:0]    byte_q;

	assign s1_move  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | s1_move;
	assign accept   = s_tvalid & s_tready;

	brf_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (s_tuser),
		.data      (s_tdata[7:0]),
		.arg       (s_tdata[17:8]),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.meta      (meta)
	);

	brf_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// store read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) meta_s1 <= meta;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			meta_q <= meta_s1;
			byte_q <= meta_s1.rd_valid ? mem_rdata : 8'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, meta_q.free, meta_q.used, byte_q};
	assign m_tuser  = {meta_q.status, meta_q.rd_valid};

	// checks
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken with both stages full");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1) else $error("accepted transaction lost");
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == 8'd0))
		else $error("byte present without valid flag");

endmodule
